[hdl/cef_pkg.sv]
// Shared types and codes for the changing element finder.
`default_nettype none

package cef_pkg;

  // Fixed field widths
  localparam int OP_W    = 2;
  localparam int BIDX_W  = 9;
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 13;
  localparam int LINE_BITS_RESET = 1728;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_FIND    = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  // Input transaction payload
  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [BIDX_W-1:0] byte_index;
    logic [BYTE_W-1:0] byte_value;
  } in_item_t;

  // Result transaction payload
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic             new_colour;
  } out_item_t;

endpackage

`default_nettype wire

[hdl/changing_element_finder_unit.sv]
// Changing element finder: line byte store plus a byte-per-cycle search sequencer.
// A find reads one line byte per cycle until it meets a change or the end of the line; a find
// on an exhausted line reads no byte. A new item is accepted only in the idle state, while a
// finished result may still wait in the output register.
// Reset (synchronous, rst_n low): search restarts before pixel 0 with white, line_bits = 1728;
// the line store is not cleared and holds garbage until loaded.
`default_nettype none

module changing_element_finder_unit #(
  parameter int MAX_LINE_BITS = 4096
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire cef_pkg::in_item_t      in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output cef_pkg::out_item_t          out_data,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [cef_pkg::POS_W-1:0] cfg_data
);

  import cef_pkg::*;

  localparam int STORE_BYTES = (MAX_LINE_BITS + 7) / 8;
  localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int SCAN_W      = POS_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_t;

  // Control and search state
  state_t            state_r, state_nxt;
  logic [POS_W-1:0]  line_bits_r, line_bits_nxt;
  logic [POS_W-1:0]  next_start_r, next_start_nxt;
  logic              colour_r, colour_nxt;
  logic              exhausted_r, exhausted_nxt;
  logic [SCAN_W-1:0] pos_r, pos_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         res_r, res_nxt;
  out_item_t         out_data_r, out_data_nxt;

  // Line store
  logic [BYTE_W-1:0] line_mem [STORE_BYTES];
  logic [BYTE_W-1:0] rdata_r;
  logic              rd_en;
  logic [ADDR_W-1:0] raddr;
  logic              mem_we;

  // Byte evaluation
  logic [POS_W-1:0]  nbits;
  logic [SCAN_W-1:0] nbits_w;
  logic [SCAN_W-1:0] base;
  logic [SCAN_W-1:0] next_base;
  logic [7:0]        bit_hit;
  logic              hit;
  logic [2:0]        hit_idx;
  logic [POS_W-1:0]  hit_pos;
  logic              want;
  logic              in_accept;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign in_accept = in_valid && in_ready;

  // Effective line length, clamped to the store size
  assign nbits = (32'(line_bits_r) > 32'(MAX_LINE_BITS)) ? POS_W'(MAX_LINE_BITS) : line_bits_r;
  assign nbits_w   = {1'b0, nbits};
  assign want      = ~colour_r;
  assign base      = {pos_r[SCAN_W-1:3], 3'b000};
  assign next_base = base + SCAN_W'(8);

  // Qualify each bit of the fetched byte: at or after the start, inside the line, wanted colour
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      bit_hit[i] = (3'(i) >= pos_r[2:0]) && ((base + SCAN_W'(i)) < nbits_w) &&
                   (rdata_r[i] == want);
    end
  end

  // Lowest qualifying bit wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (bit_hit[i]) begin
        hit     = 1'b1;
        hit_idx = 3'(i);
      end
    end
  end

  assign hit_pos = POS_W'(base + SCAN_W'(hit_idx) + SCAN_W'(1));

  // Next-state logic
  always_comb begin
    state_nxt      = state_r;
    line_bits_nxt  = line_bits_r;
    next_start_nxt = next_start_r;
    colour_nxt     = colour_r;
    exhausted_nxt  = exhausted_r;
    pos_nxt        = pos_r;
    res_nxt        = res_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r;
    rd_en          = 1'b0;
    raddr          = ADDR_W'(next_start_r >> 3);
    mem_we         = 1'b0;

    if (cfg_valid && cfg_ready) begin
      line_bits_nxt = cfg_data;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_data.operation)
            OP_LOAD: begin
              mem_we = (32'(in_data.byte_index) < 32'(STORE_BYTES));
            end
            OP_FIND: begin
              if (exhausted_r || (next_start_r >= nbits)) begin
                res_nxt       = '0;
                exhausted_nxt = 1'b1;
                state_nxt     = ST_RESULT;
              end else begin
                rd_en     = 1'b1;
                pos_nxt   = {1'b0, next_start_r};
                state_nxt = ST_SCAN;
              end
            end
            OP_RESTART: begin
              next_start_nxt = '0;
              colour_nxt     = 1'b0;
              exhausted_nxt  = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          res_nxt.found      = 1'b1;
          res_nxt.position   = hit_pos;
          res_nxt.new_colour = want;
          next_start_nxt     = hit_pos;
          colour_nxt         = want;
          state_nxt          = ST_RESULT;
        end else if (next_base < nbits_w) begin
          rd_en   = 1'b1;
          raddr   = ADDR_W'(next_base >> 3);
          pos_nxt = next_base;
        end else begin
          res_nxt       = '0;
          exhausted_nxt = 1'b1;
          state_nxt     = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      line_bits_r  <= POS_W'(LINE_BITS_RESET);
      next_start_r <= '0;
      colour_r     <= 1'b0;
      exhausted_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      line_bits_r  <= line_bits_nxt;
      next_start_r <= next_start_nxt;
      colour_r     <= colour_nxt;
      exhausted_r  <= exhausted_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    pos_r      <= pos_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // Line store write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[ADDR_W'(in_data.byte_index)] <= in_data.byte_value;
    end
  end

  // Line store read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= line_mem[raddr];
    end
  end

  // A scan never runs on an exhausted line and stays inside the line
  a_scan_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (!exhausted_r && (pos_r < nbits_w)))
    else $error("scan running outside the line");

  // Restart returns the search to before pixel 0, white
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_data.operation == OP_RESTART)) |=>
      (!exhausted_r && (next_start_r == '0) && !colour_r))
    else $error("restart did not clear search state");

  // A found result points at a real pixel
  a_found_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.found) |-> (out_data_r.position != '0))
    else $error("found result with zero position");

  // A not-found result carries zero fields
  a_notfound_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.found) |->
      ((out_data_r.position == '0) && !out_data_r.new_colour))
    else $error("not-found result with nonzero fields");

  // A hit moves the start past the previous change and flips the colour
  a_hit_update: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) && hit) |=>
      ((next_start_r > $past(next_start_r)) && (colour_r != $past(colour_r))))
    else $error("hit did not advance search state");

endmodule

`default_nettype wire

[bench/changing_element_finder_checker.sv]
// Scoreboard for the changing element finder: predicts each find result and compares.
`timescale 1ns / 1ps

module changing_element_finder_checker #(
  parameter int MAX_LINE_BITS = 4096
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire logic                   in_ready,
  input  wire cef_pkg::in_item_t      in_data,
  input  wire logic                   out_valid,
  input  wire logic                   out_ready,
  input  wire cef_pkg::out_item_t     out_data,
  input  wire logic                   cfg_valid,
  input  wire logic                   cfg_ready,
  input  wire logic [cef_pkg::POS_W-1:0] cfg_data,
  output int                          fail_count,
  output int                          results_pending
);
  import cef_pkg::*;

  localparam int STORE_BYTES  = (MAX_LINE_BITS + 7) / 8;
  localparam int REPORT_LIMIT = 10;

  // Shadow copy of the line and of the search position
  logic [BYTE_W-1:0] line_mem [STORE_BYTES];
  int                last_pos;
  logic              cur_colour;
  logic              exhausted;
  logic [POS_W-1:0]  line_len;

  // Find results still owed by the block, oldest first
  out_item_t         pending_finds [$];
  int                n_fail;

  // Advance the shadow search to the next colour change
  function automatic out_item_t scan_next_change();
    out_item_t res;
    int        nbits;
    int        p;
    logic      want_colour;
    res = '0;
    if (exhausted)
      return res;
    nbits = (int'(line_len) > MAX_LINE_BITS) ? MAX_LINE_BITS : int'(line_len);
    want_colour = ~cur_colour;
    for (p = last_pos + 1; p < nbits; p++) begin
      if (line_mem[p / 8][p % 8] == want_colour) begin
        last_pos       = p;
        cur_colour     = want_colour;
        res.found      = 1'b1;
        res.position   = POS_W'(p + 1);
        res.new_colour = want_colour;
        return res;
      end
    end
    exhausted = 1'b1;
    return res;
  endfunction

  // Watch all three channels; results are retired before new transactions are predicted
  always @(posedge clk) begin : watch
    out_item_t got;
    out_item_t want;
    if (!rst_n) begin
      last_pos   = -1;
      cur_colour = 1'b0;
      exhausted  = 1'b0;
      line_len   = POS_W'(LINE_BITS_RESET);
      pending_finds.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = out_data;
        if (pending_finds.size() == 0) begin
          n_fail++;
          if (n_fail <= REPORT_LIMIT)
            $display("%0t: unexpected result found=%0d pos=%0d colour=%0d",
                     $realtime, got.found, got.position, got.new_colour);
        end else begin
          want = pending_finds.pop_front();
          if (got.found !== want.found || got.position !== want.position ||
              got.new_colour !== want.new_colour) begin
            n_fail++;
            if (n_fail <= REPORT_LIMIT)
              $display({"%0t: mismatch expected found=%0d pos=%0d colour=%0d, ",
                        "got found=%0d pos=%0d colour=%0d"},
                       $realtime, want.found, want.position, want.new_colour,
                       got.found, got.position, got.new_colour);
          end
        end
      end
      if (cfg_valid && cfg_ready)
        line_len = cfg_data;
      if (in_valid && in_ready) begin
        case (in_data.operation)
          OP_LOAD: begin
            if (int'(in_data.byte_index) < STORE_BYTES)
              line_mem[in_data.byte_index] = in_data.byte_value;
          end
          OP_FIND: begin
            pending_finds.push_back(scan_next_change());
          end
          OP_RESTART: begin
            last_pos   = -1;
            cur_colour = 1'b0;
            exhausted  = 1'b0;
          end
          default: ;
        endcase
      end
    end
    fail_count      <= n_fail;
    results_pending <= pending_finds.size();
  end

endmodule

[bench/changing_element_finder_unit_test.sv]
// Stimulus, handshake pacing and verdict for the changing element finder.
`timescale 1ns / 1ps

module changing_element_finder_unit_test;
  import cef_pkg::*;

  localparam int              MAX_LINE_BITS = 4096;
  localparam int              STORE_BYTES   = (MAX_LINE_BITS + 7) / 8;
  localparam logic [OP_W-1:0] OP_UNUSED     = 2'd3;
  localparam int              TARGET_ITEMS  = 1150;
  localparam int              STALL_LIMIT   = 5000;
  localparam int              SETTLE_CYCLES = 8;
  localparam int              LONG_HOLD     = 250;
  localparam int              HOLD_EVERY    = 250;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [POS_W-1:0]   cfg_data;

  int                 fail_count;
  int                 results_pending;

  // Stimulus bookkeeping
  bit                 loaded [STORE_BYTES];
  int                 line_len_now;
  int                 items_sent;
  bit                 no_gaps;
  int                 finds_seen;
  int                 next_hold_at;
  int                 idle_cycles;

  changing_element_finder_unit #(
    .MAX_LINE_BITS(MAX_LINE_BITS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  changing_element_finder_checker #(
    .MAX_LINE_BITS(MAX_LINE_BITS)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .results_pending(results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Sender gap: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Line content biased toward long runs and single transitions
  function automatic int pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20)
      return 0;
    if (r < 40)
      return 8'hff;
    if (r < 55)
      return (8'hff << $urandom_range(1, 7)) & 8'hff;
    if (r < 65)
      return (8'hff >> $urandom_range(1, 7)) & 8'hff;
    return $urandom_range(0, 255);
  endfunction

  function automatic int bytes_in_line();
    int n;
    n = (line_len_now > MAX_LINE_BITS) ? MAX_LINE_BITS : line_len_now;
    return (n + 7) / 8;
  endfunction

  // Offer one transaction and hold it until accepted
  task automatic send(input logic [OP_W-1:0] op, input int idx, input int val);
    in_item_t item;
    int       gap;
    item.operation  = op;
    item.byte_index = BIDX_W'(idx);
    item.byte_value = BYTE_W'(val);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OP_LOAD)
      loaded[idx] = 1'b1;
    if (op != OP_UNUSED)
      items_sent++;
  endtask

  // Drain all owed results, then let the last load or restart finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_line_len(input int len);
    cfg_valid <= 1'b1;
    cfg_data  <= POS_W'(len);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    line_len_now = len;
  endtask

  // Every byte a find may read must hold known content
  task automatic fill_line();
    int need;
    need = bytes_in_line();
    for (int b = 0; b < need; b++)
      if (!loaded[b])
        send(OP_LOAD, b, pick_byte());
  endtask

  task automatic run_phase(input int ph);
    int new_len;
    bit reconf;
    int n;
    int r;
    int need;
    no_gaps = ($urandom_range(0, 3) == 0);
    reconf = 1'b1;
    case (ph % 16)
      2:       new_len = 0;
      4:       new_len = 1;
      6:       new_len = 8191;
      9:       new_len = MAX_LINE_BITS;
      12:      new_len = LINE_BITS_RESET;
      14:      new_len = 8;
      default: begin
        new_len = $urandom_range(1, 96);
        reconf  = $urandom_range(0, 1);
      end
    endcase
    if (reconf) begin
      wait_idle();
      write_line_len(new_len);
    end
    fill_line();
    need = bytes_in_line();
    if ($urandom_range(0, 9) < 7) begin
      // restart then mostly finds, with edits to the line in between
      send(OP_RESTART, $urandom_range(0, 511), $urandom_range(0, 255));
      n = $urandom_range(3, 30);
      repeat (n) begin
        r = $urandom_range(0, 9);
        if (r < 7)
          send(OP_FIND, $urandom_range(0, 511), $urandom_range(0, 255));
        else if (r < 9 && need > 0)
          send(OP_LOAD, $urandom_range(0, need - 1), pick_byte());
        else
          send(OP_UNUSED, $urandom_range(0, 511), $urandom_range(0, 255));
      end
    end else begin
      // noise: any operation, loads anywhere in the store
      n = $urandom_range(10, 25);
      repeat (n) begin
        r = $urandom_range(0, 9);
        if (r < 4)
          send(OP_FIND, $urandom_range(0, 511), $urandom_range(0, 255));
        else if (r < 7)
          send(OP_LOAD, $urandom_range(0, 511), pick_byte());
        else if (r < 9)
          send(OP_RESTART, $urandom_range(0, 511), $urandom_range(0, 255));
        else
          send(OP_UNUSED, $urandom_range(0, 511), $urandom_range(0, 255));
      end
    end
  endtask

  // Main sequence
  initial begin
    int ph;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    items_sent   = 0;
    no_gaps      = 1'b0;
    line_len_now = LINE_BITS_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: two-byte line, runs, exhaustion, restart, edits mid-search
    write_line_len(16);
    send(OP_LOAD, 0, 8'h00);
    send(OP_LOAD, 1, 8'hff);
    send(OP_FIND, 0, 0);          // first black pixel at 9
    send(OP_FIND, 0, 0);          // runs off the end
    send(OP_FIND, 511, 8'hff);    // stays exhausted
    send(OP_RESTART, 0, 0);
    send(OP_LOAD, 0, 8'hff);
    send(OP_FIND, 0, 0);          // change on the very first pixel
    send(OP_FIND, 0, 0);          // all black to the end
    send(OP_UNUSED, 511, 8'hff);  // ignored
    send(OP_RESTART, 0, 0);
    send(OP_LOAD, 0, 8'h55);
    send(OP_FIND, 0, 0);
    send(OP_FIND, 0, 0);
    send(OP_LOAD, 0, 8'h00);      // line edited under an active search
    send(OP_FIND, 0, 0);
    send(OP_LOAD, 511, 8'h80);    // last store byte, outside this line
    send(OP_FIND, 0, 0);
    send(OP_FIND, 0, 0);
    send(OP_RESTART, 0, 0);
    send(OP_FIND, 0, 0);
    send(OP_FIND, 0, 0);

    // Random phases over several line lengths
    ph = 0;
    while (items_sent < TARGET_ITEMS) begin
      run_phase(ph);
      ph++;
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Count accepted finds to schedule the long receiver hold-offs
  always @(posedge clk)
    if (rst_n && in_valid && in_ready && in_data.operation == OP_FIND)
      finds_seen <= finds_seen + 1;

  // Receiver pacing: random stretches, plus long hold-offs so the input backs up
  initial begin
    int r;
    int span;
    out_ready <= 1'b0;
    next_hold_at = 25;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (finds_seen >= next_hold_at) begin
        next_hold_at = next_hold_at + HOLD_EVERY;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_ready <= 1'b1;
          span = $urandom_range(1, 30);
        end else if (r < 88) begin
          out_ready <= 1'b0;
          span = $urandom_range(1, 3);
        end else begin
          out_ready <= 1'b0;
          span = $urandom_range(5, 40);
        end
        repeat (span) @(posedge clk);
      end
    end
  end

  // Watchdog: too long without any transaction on any channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

[changing_element_finder_unit.f]
hdl/cef_pkg.sv
hdl/changing_element_finder_unit.sv
bench/changing_element_finder_checker.sv
bench/changing_element_finder_unit_test.sv
